[hw/rtl/rae_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rae_pkg: reflectance / ambient estimator types
// Payload structs and register indexes used by reflectance_ambient_estimator.
// ----------------------------------------------------------------------------
package rae_pkg;

   localparam int SB = 16;
   localparam int NCH = 3;

   typedef struct packed {
      logic [SB-1:0] cam2_blue;
      logic [SB-1:0] cam2_green;
      logic [SB-1:0] cam2_red;
      logic [SB-1:0] proj2_blue;
      logic [SB-1:0] proj2_green;
      logic [SB-1:0] proj2_red;
      logic [SB-1:0] cam1_blue;
      logic [SB-1:0] cam1_green;
      logic [SB-1:0] cam1_red;
      logic [SB-1:0] proj1_blue;
      logic [SB-1:0] proj1_green;
      logic [SB-1:0] proj1_red;
   } req_type;

   typedef struct packed {
      logic [NCH-1:0]     degenerate_mask;
      logic signed [15:0] amb_blue;
      logic signed [15:0] amb_green;
      logic signed [15:0] amb_red;
      logic [15:0]        refl_blue;
      logic [15:0]        refl_green;
      logic [15:0]        refl_red;
   } rsp_type;

   localparam logic [2:0] REG_FULL_RED   = 3'd0;
   localparam logic [2:0] REG_FULL_GREEN = 3'd1;
   localparam logic [2:0] REG_FULL_BLUE  = 3'd2;
   localparam logic [2:0] REG_DARK_RED   = 3'd3;
   localparam logic [2:0] REG_DARK_GREEN = 3'd4;
   localparam logic [2:0] REG_DARK_BLUE  = 3'd5;

endpackage

[hw/rtl/rae_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rae_divider: pipelined restoring divider
// One quotient bit per stage; a quotient of 2^17 or more sets the top bit (enough for saturation).
// Stall freezes all stages.
// ----------------------------------------------------------------------------
module rae_divider #(
   parameter int NW = 64,
   parameter int DW = 48,
   parameter int QW = 18,
   parameter int TW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag,
   output logic [QW-1:0] quo,
   output logic [TW-1:0] tag_out
);
   // The numerator's top bits yield a prefix quotient; if num>>(QW-1) >= den
   // the quotient is at least 2^(QW-1) and saturates. Stage 0 checks that.
   localparam int LOW = QW - 1;

   logic [NW-1:0] n_ff [LOW+1];
   logic [DW:0]   r_ff [LOW+1];
   logic [DW-1:0] d_ff [LOW+1];
   logic [QW-1:0] q_ff [LOW+1];
   logic [TW-1:0] t_ff [LOW+1];

   logic [NW-1:0] hi_part;
   logic          big;
   assign hi_part = num >> LOW;
   assign big     = (hi_part >= NW'(den));

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff[0] <= num;
         // remainder of the prefix is only needed when not saturated;
         // then hi_part < den fits in DW bits
         r_ff[0] <= {1'b0, hi_part[DW-1:0]};
         d_ff[0] <= den;
         q_ff[0] <= big ? QW'(1) << LOW : '0;
         t_ff[0] <= tag;
         for (int s = 0; s < LOW; s++) begin
            logic [DW+1:0] tr;
            tr = {r_ff[s], n_ff[s][LOW-1-s]};
            n_ff[s+1] <= n_ff[s];
            d_ff[s+1] <= d_ff[s];
            t_ff[s+1] <= t_ff[s];
            if (tr >= {2'b00, d_ff[s]}) begin
               r_ff[s+1] <= (DW+1)'(tr - {2'b00, d_ff[s]});
               q_ff[s+1] <= q_ff[s] | (QW'(1) << (LOW-1-s));
            end else begin
               r_ff[s+1] <= (DW+1)'(tr);
               q_ff[s+1] <= q_ff[s];
            end
         end
      end
   end

   assign quo     = q_ff[LOW];
   assign tag_out = t_ff[LOW];

   logic unused_rst;
   assign unused_rst = reset;
endmodule

[hw/rtl/reflectance_ambient_estimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflectance_ambient_estimator: per-pixel reflectance and ambient estimator
// Solves C = K((full-dark)P + dark + F) for K and F per color channel.
// ----------------------------------------------------------------------------
//  channel  | ports               | payload
//  request  | req_valid/req_ready | rae_pkg::req_type (two projections, captures)
//  response | rsp_valid/rsp_ready | rae_pkg::rsp_type (refl, amb, degenerate)
//  config   | psel..pready APB    | full/dark levels, byte address 4*index
//
//  One pixel per clock sustained while rsp_ready does not stall it. The pipeline
//  is 4 setup stages, the 18-stage divider pipelines and the output stage.
//  Reset clears only the valid bits and the level registers.
//  rsp_ready low freezes the whole pipeline; req_ready follows rsp_ready
//  or an empty output slot, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module reflectance_ambient_estimator #(
   parameter int QBITS = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rae_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rae_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int SB = rae_pkg::SB;
   localparam int NC = rae_pkg::NCH;
   localparam int DEP = QBITS + 4;   // valid pipeline depth before output reg

   // ---------------- configuration ----------------
   logic [SB-1:0] full_ff [NC];
   logic [SB-1:0] dark_ff [NC];
   logic [2:0]    idx;
   assign idx    = paddr[4:2];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NC; c++) begin
            full_ff[c] <= '0;
            dark_ff[c] <= '0;
         end
      end else if (psel && penable && pwrite) begin
         case (idx)
            rae_pkg::REG_FULL_RED:   full_ff[0] <= pwdata[SB-1:0];
            rae_pkg::REG_FULL_GREEN: full_ff[1] <= pwdata[SB-1:0];
            rae_pkg::REG_FULL_BLUE:  full_ff[2] <= pwdata[SB-1:0];
            rae_pkg::REG_DARK_RED:   dark_ff[0] <= pwdata[SB-1:0];
            rae_pkg::REG_DARK_GREEN: dark_ff[1] <= pwdata[SB-1:0];
            rae_pkg::REG_DARK_BLUE:  dark_ff[2] <= pwdata[SB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         rae_pkg::REG_FULL_RED:   prdata = 32'(full_ff[0]);
         rae_pkg::REG_FULL_GREEN: prdata = 32'(full_ff[1]);
         rae_pkg::REG_FULL_BLUE:  prdata = 32'(full_ff[2]);
         rae_pkg::REG_DARK_RED:   prdata = 32'(dark_ff[0]);
         rae_pkg::REG_DARK_GREEN: prdata = 32'(dark_ff[1]);
         rae_pkg::REG_DARK_BLUE:  prdata = 32'(dark_ff[2]);
         default:                 prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   // Global advance: whole pipe moves when the output slot is free or drains.
   logic adv;
   logic [DEP-1:0] v_ff;
   logic out_v_ff;
   assign adv       = !out_v_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff     <= {v_ff[DEP-2:0], req_valid};
         out_v_ff <= v_ff[DEP-1];
      end
   end
   assign rsp_valid = out_v_ff;

   // ---------------- unpack ----------------
   logic [SB-1:0] p1 [NC], c1 [NC], p2 [NC], c2 [NC];
   always_comb begin
      p1[0] = req_data.proj1_red;  p1[1] = req_data.proj1_green; p1[2] = req_data.proj1_blue;
      c1[0] = req_data.cam1_red;   c1[1] = req_data.cam1_green;  c1[2] = req_data.cam1_blue;
      p2[0] = req_data.proj2_red;  p2[1] = req_data.proj2_green; p2[2] = req_data.proj2_blue;
      c2[0] = req_data.cam2_red;   c2[1] = req_data.cam2_green;  c2[2] = req_data.cam2_blue;
   end

   logic [15:0]        refl [NC];
   logic signed [15:0] amb  [NC];
   logic [NC-1:0]      dmask;

   for (genvar c = 0; c < NC; c++) begin : g_ch
      // stage 1: differences, single products (<=17x17)
      logic signed [SB+1:0] d1_ff, dp1_ff, dc1_ff;
      logic [2*SB:0]        fa_ff, da_ff, fb_ff, db_ff;   // full*p, dark*(2^SB-p)
      logic [SB-1:0]        c1_1_ff, c2_1_ff;
      always_ff @(posedge clock) begin
         if (adv) begin
            d1_ff   <= $signed({2'b0, full_ff[c]}) - $signed({2'b0, dark_ff[c]});
            dp1_ff  <= $signed({2'b0, p2[c]}) - $signed({2'b0, p1[c]});
            dc1_ff  <= $signed({2'b0, c2[c]}) - $signed({2'b0, c1[c]});
            fa_ff   <= (2*SB+1)'(full_ff[c]) * (2*SB+1)'(p2[c]);
            fb_ff   <= (2*SB+1)'(full_ff[c]) * (2*SB+1)'(p1[c]);
            da_ff   <= (2*SB+1)'(dark_ff[c])
                       * (2*SB+1)'((SB+1)'(1 << SB) - (SB+1)'(p2[c]));
            db_ff   <= (2*SB+1)'(dark_ff[c])
                       * (2*SB+1)'((SB+1)'(1 << SB) - (SB+1)'(p1[c]));
            c1_1_ff <= c1[c];
            c2_1_ff <= c2[c];
         end
      end

      // stage 2: a, b sums; K denominator; abs values
      logic [2*SB+1:0]   a2_ff, b2_ff;
      logic [2*SB+1:0]   akd2_ff;
      logic [SB:0]       adc2_ff;
      logic              kpos2_ff, dcn2_ff, deg2_ff;
      logic [SB-1:0]     c1_2_ff, c2_2_ff;
      logic signed [2*SB+3:0] kden;
      assign kden = d1_ff * dp1_ff;
      always_ff @(posedge clock) begin
         if (adv) begin
            a2_ff    <= (2*SB+2)'(fa_ff) + (2*SB+2)'(da_ff);
            b2_ff    <= (2*SB+2)'(fb_ff) + (2*SB+2)'(db_ff);
            akd2_ff  <= (2*SB+2)'(kden[2*SB+3] ? -kden : kden);
            adc2_ff  <= (SB+1)'(dc1_ff[SB+1] ? -dc1_ff : dc1_ff);
            kpos2_ff <= (dc1_ff[SB+1] == kden[2*SB+3]);
            dcn2_ff  <= dc1_ff[SB+1];
            deg2_ff  <= (d1_ff == 0) || (dp1_ff == 0) || (dc1_ff == 0);
            c1_2_ff  <= c1_1_ff;
            c2_2_ff  <= c2_1_ff;
         end
      end

      // stage 3: c1*a, c2*b (16x34 products)
      logic [3*SB+1:0] t1_3_ff, t2_3_ff;
      logic [2*SB+1:0] akd3_ff;
      logic [SB:0]     adc3_ff;
      logic            kpos3_ff, dcn3_ff, deg3_ff;
      always_ff @(posedge clock) begin
         if (adv) begin
            t1_3_ff  <= (3*SB+2)'(c1_2_ff) * (3*SB+2)'(a2_ff);
            t2_3_ff  <= (3*SB+2)'(c2_2_ff) * (3*SB+2)'(b2_ff);
            akd3_ff  <= akd2_ff;
            adc3_ff  <= adc2_ff;
            kpos3_ff <= kpos2_ff;
            dcn3_ff  <= dcn2_ff;
            deg3_ff  <= deg2_ff;
         end
      end

      // stage 4: ambient numerator magnitude and sign
      logic [3*SB+1:0] n4_ff;
      logic [2*SB+1:0] akd4_ff;
      logic [SB:0]     adc4_ff;
      logic            kpos4_ff, neg4_ff, deg4_ff;
      logic            t_less;
      assign t_less = (t1_3_ff < t2_3_ff);
      always_ff @(posedge clock) begin
         if (adv) begin
            n4_ff    <= t_less ? t2_3_ff - t1_3_ff : t1_3_ff - t2_3_ff;
            neg4_ff  <= t_less ^ dcn3_ff;
            akd4_ff  <= akd3_ff;
            adc4_ff  <= adc3_ff;
            kpos4_ff <= kpos3_ff;
            deg4_ff  <= deg3_ff;
         end
      end

      // dividers: K = adc<<(SB+12) / akd ; F = n / (adc<<(2SB-12))
      localparam int KNW = SB + 13 + SB;
      localparam int FNW = 3 * SB + 2;
      logic [QBITS-1:0] kq, fq;
      logic [2:0]       ktag, ftag_unused;
      rae_divider #(.NW(KNW), .DW(2*SB+2), .QW(QBITS), .TW(3)) u_kdiv (
         .clock(clock), .reset(reset), .adv(adv),
         .num(KNW'(adc4_ff) << (SB + 12)),
         .den(deg4_ff ? (2*SB+2)'(1) : akd4_ff),
         .tag({deg4_ff, neg4_ff, kpos4_ff}),
         .quo(kq), .tag_out(ktag));
      rae_divider #(.NW(FNW), .DW(3*SB-11), .QW(QBITS), .TW(3)) u_fdiv (
         .clock(clock), .reset(reset), .adv(adv),
         .num(n4_ff),
         .den(deg4_ff ? (3*SB-11)'(1) : (3*SB-11)'(adc4_ff) << (2*SB-12)),
         .tag(3'b000),
         .quo(fq), .tag_out(ftag_unused));

      always_comb begin
         dmask[c] = ktag[2];
         if (ktag[2]) begin
            refl[c] = '0;
            amb[c]  = '0;
         end else begin
            refl[c] = !ktag[0] ? 16'd0 : (kq > QBITS'(65535)) ? 16'hFFFF : kq[15:0];
            if (ktag[1])
               amb[c] = (fq >= QBITS'(32768)) ? -16'sd32768 : 16'(-$signed({1'b0, fq}));
            else
               amb[c] = (fq >= QBITS'(32767)) ? 16'sd32767 : $signed(fq[15:0]);
         end
      end
   end

   // output register
   rae_pkg::rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.refl_red        <= refl[0];
         out_ff.refl_green      <= refl[1];
         out_ff.refl_blue       <= refl[2];
         out_ff.amb_red         <= amb[0];
         out_ff.amb_green       <= amb[1];
         out_ff.amb_blue        <= amb[2];
         out_ff.degenerate_mask <= dmask;
      end
   end
   assign rsp_data = out_ff;

   // ---------------- assertions ----------------
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed under stall");
   a_stall_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("pipeline moved during stall");
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate_mask[0] |-> rsp_data.refl_red == 16'd0)
      else $error("degenerate channel not zeroed");
endmodule
